// ===== hw/rtl/sssp_pkg.sv =====
// shared types and constants for the shortest path engine
// used by sssp_ctrl, sssp_dp and the top level
`timescale 1ns / 1ps
package sssp_pkg;

  localparam int MAX_NODES_DEF   = 1024;
  localparam int MAX_EDGES_DEF   = 4096;
  localparam int WEIGHT_BITS_DEF = 16;

  localparam int NODE_W = 10;
  localparam int WIN_W  = 16;
  localparam int DIST_W = 32;
  localparam int STAT_W = 3;
  localparam int KIND_W = 2;

  localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_RUN   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_QUERY = 2'd2;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd3;

  localparam logic [STAT_W-1:0] ST_RUN_OK  = 3'd0;
  localparam logic [STAT_W-1:0] ST_RUN_NEG = 3'd1;
  localparam logic [STAT_W-1:0] ST_VALID   = 3'd2;
  localparam logic [STAT_W-1:0] ST_UNREACH = 3'd3;
  localparam logic [STAT_W-1:0] ST_INVALID = 3'd4;

  localparam logic [2:0] REG_NODE_COUNT = 3'd0;

  typedef struct packed {
    logic load;
    logic clear;
    logic latch;
    logic clr_start;
    logic clr_step;
    logic src_set;
    logic pass_start;
    logic pass_next;
    logic edge_rd;
    logic node_rd;
    logic eval;
    logic wr;
    logic apply;
    logic res_run;
    logic q_rd;
    logic res_query;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic edge_done;
    logic pass_lt;
    logic changed;
    logic out_free;
  } sts_t;

endpackage

// ===== hw/rtl/sssp_ctrl.sv =====
// sequencer for loads, clears, runs and queries
// depends on sssp_pkg, drives sssp_dp through cmd_t / sts_t
`timescale 1ns / 1ps
module sssp_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [sssp_pkg::KIND_W-1:0] in_kind,
  input  sssp_pkg::sts_t             sts,
  output sssp_pkg::cmd_t             cmd
);
  import sssp_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CLR   = 4'd1;
  localparam logic [3:0] S_SRC   = 4'd2;
  localparam logic [3:0] S_PSTRT = 4'd3;
  localparam logic [3:0] S_ERD   = 4'd4;
  localparam logic [3:0] S_NRD   = 4'd5;
  localparam logic [3:0] S_EVAL  = 4'd6;
  localparam logic [3:0] S_WR    = 4'd7;
  localparam logic [3:0] S_PEND  = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;
  localparam logic [3:0] S_QRD   = 4'd10;
  localparam logic [3:0] S_QOUT  = 4'd11;

  logic [3:0] state, state_next;
  logic       apply, apply_next;
  logic       acc;

  assign in_ready = (state == S_IDLE);
  assign acc      = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      apply <= 1'b0;
    end else begin
      state <= state_next;
      apply <= apply_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    apply_next = apply;
    cmd.apply  = apply;
    case (state)
      S_IDLE: begin
        if (acc) begin
          case (in_kind)
            KIND_LOAD:  cmd.load = 1'b1;
            KIND_CLEAR: cmd.clear = 1'b1;
            KIND_RUN: begin
              cmd.latch     = 1'b1;
              cmd.clr_start = 1'b1;
              state_next    = S_CLR;
            end
            default: begin
              cmd.latch  = 1'b1;
              state_next = S_QRD;
            end
          endcase
        end
      end
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_next = S_SRC;
      end
      S_SRC: begin
        cmd.src_set = 1'b1;
        apply_next  = 1'b1;
        state_next  = S_PSTRT;
      end
      S_PSTRT: begin
        // out of relaxation passes: go straight to the cycle check pass
        if (apply && !sts.pass_lt) apply_next = 1'b0;
        cmd.pass_start = 1'b1;
        state_next     = S_ERD;
      end
      S_ERD: begin
        if (sts.edge_done) begin
          state_next = S_PEND;
        end else begin
          cmd.edge_rd = 1'b1;
          state_next  = S_NRD;
        end
      end
      S_NRD: begin
        cmd.node_rd = 1'b1;
        state_next  = S_EVAL;
      end
      S_EVAL: begin
        cmd.eval   = 1'b1;
        state_next = S_WR;
      end
      S_WR: begin
        cmd.wr     = 1'b1;
        state_next = S_ERD;
      end
      S_PEND: begin
        if (apply) begin
          if (!sts.changed) apply_next = 1'b0;
          else cmd.pass_next = 1'b1;
          state_next = S_PSTRT;
        end else begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.res_run = 1'b1;
          state_next  = S_IDLE;
        end
      end
      S_QRD: begin
        cmd.q_rd   = 1'b1;
        state_next = S_QOUT;
      end
      S_QOUT: begin
        if (sts.out_free) begin
          cmd.res_query = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ===== hw/rtl/sssp_dp.sv =====
// datapath: edge store, node distance store, relax unit and result register
// depends on sssp_pkg, sequenced by sssp_ctrl
`timescale 1ns / 1ps
module sssp_dp #(
  parameter int MAX_NODES   = sssp_pkg::MAX_NODES_DEF,
  parameter int MAX_EDGES   = sssp_pkg::MAX_EDGES_DEF,
  parameter int WEIGHT_BITS = sssp_pkg::WEIGHT_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  sssp_pkg::cmd_t                    cmd,
  output sssp_pkg::sts_t                    sts,
  input  logic [sssp_pkg::NODE_W-1:0]       node_count,
  input  logic [sssp_pkg::NODE_W-1:0]       in_from,
  input  logic [sssp_pkg::NODE_W-1:0]       in_to,
  input  logic signed [sssp_pkg::WIN_W-1:0] in_weight,
  output logic                              m_valid,
  input  logic                              m_ready,
  output logic [sssp_pkg::STAT_W-1:0]       out_status,
  output logic [sssp_pkg::DIST_W-1:0]       out_distance,
  output logic                              out_ovf
);
  import sssp_pkg::*;

  localparam int NAW = $clog2(MAX_NODES);
  localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int ECW = $clog2(MAX_EDGES + 1);
  localparam int EW  = 2 * NODE_W + WEIGHT_BITS;
  localparam int SW  = DIST_W + 2;
  localparam int NW  = DIST_W + 1;

  function automatic logic in_rng(input logic [NODE_W-1:0] n,
                                  input logic [NODE_W-1:0] cnt);
    in_rng = (n != '0) && (n <= cnt) && (32'(n) < MAX_NODES);
  endfunction

  logic [EW-1:0]          edge_mem [MAX_EDGES];
  logic [NW-1:0]          node_mem [MAX_NODES];
  logic [ECW-1:0]         edge_cnt;
  logic                   ovf;
  logic                   cycle_found;
  logic                   ran;
  logic                   changed;
  logic [NAW-1:0]         clr_k;
  logic [ECW-1:0]         eidx;
  logic [NODE_W-1:0]      pass;
  logic [NODE_W-1:0]      qnode;
  logic [EW-1:0]          edge_q;
  logic [NW-1:0]          rd_a, rd_b;
  logic                   ev_ok;
  logic [WEIGHT_BITS-1:0] ev_w;
  logic [NODE_W-1:0]      ev_b;
  logic                   imp;
  logic [DIST_W-1:0]      cand_q;

  logic                          full;
  logic [NODE_W-1:0]             ea, eb;
  logic signed [DIST_W-1:0]      da;
  logic signed [WEIGHT_BITS-1:0] wv;
  logic signed [SW-1:0]          sum;
  logic                          sat;
  logic [DIST_W-1:0]             cand;
  logic                          improve;
  logic                          q_hit;

  assign full = (edge_cnt == ECW'(MAX_EDGES));
  assign ea   = edge_q[NODE_W-1:0];
  assign eb   = edge_q[2*NODE_W-1:NODE_W];
  assign da   = rd_a[DIST_W-1:0];
  assign wv   = ev_w;
  assign sum  = SW'(da) + SW'(wv);
  // saturate when the top three bits disagree
  assign sat  = (sum[SW-1:DIST_W-1] != '0) && (sum[SW-1:DIST_W-1] != '1);
  assign cand = sat ? (sum[SW-1] ? {1'b1, {(DIST_W-1){1'b0}}} : {1'b0, {(DIST_W-1){1'b1}}})
                    : sum[DIST_W-1:0];
  assign improve = ev_ok && rd_a[DIST_W] &&
                   (!rd_b[DIST_W] || ($signed(cand) < $signed(rd_b[DIST_W-1:0])));
  assign q_hit = ran && in_rng(qnode, node_count) && rd_a[DIST_W];

  assign sts.clr_last  = (clr_k == NAW'(MAX_NODES - 1));
  assign sts.edge_done = (eidx == edge_cnt);
  assign sts.pass_lt   = (pass < node_count);
  assign sts.changed   = changed;
  assign sts.out_free  = !m_valid || m_ready;

  // edge store
  always_ff @(posedge clk) begin
    if (cmd.load && !full) begin
      edge_mem[edge_cnt[EAW-1:0]] <= {WEIGHT_BITS'(in_weight), in_to, in_from};
    end
    if (cmd.edge_rd) begin
      edge_q <= edge_mem[eidx[EAW-1:0]];
    end
  end

  // node store: reached bit on top of the distance
  always_ff @(posedge clk) begin
    if (cmd.clr_step) begin
      node_mem[clr_k] <= '0;
    end else if (cmd.src_set && in_rng(qnode, node_count)) begin
      node_mem[NAW'(qnode)] <= {1'b1, {DIST_W{1'b0}}};
    end else if (cmd.wr && cmd.apply && imp) begin
      node_mem[NAW'(ev_b)] <= {1'b1, cand_q};
    end
    if (cmd.q_rd) begin
      rd_a <= node_mem[NAW'(qnode)];
    end else if (cmd.node_rd) begin
      rd_a <= node_mem[NAW'(ea)];
    end
    if (cmd.node_rd) begin
      rd_b <= node_mem[NAW'(eb)];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) qnode <= in_from;
    if (cmd.clr_start) clr_k <= '0;
    else if (cmd.clr_step) clr_k <= clr_k + 1'b1;
    if (cmd.node_rd) begin
      ev_ok <= in_rng(ea, node_count) && in_rng(eb, node_count);
      ev_w  <= edge_q[EW-1:2*NODE_W];
      ev_b  <= eb;
    end
    if (cmd.eval) begin
      imp    <= improve;
      cand_q <= cand;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      edge_cnt     <= '0;
      ovf          <= 1'b0;
      cycle_found  <= 1'b0;
      ran          <= 1'b0;
      changed      <= 1'b0;
      eidx         <= '0;
      pass         <= '0;
      m_valid      <= 1'b0;
      out_status   <= ST_RUN_OK;
      out_distance <= '0;
      out_ovf      <= 1'b0;
    end else begin
      if (cmd.clear) begin
        edge_cnt <= '0;
        ovf      <= 1'b0;
      end else if (cmd.load) begin
        if (full) ovf <= 1'b1;
        else edge_cnt <= edge_cnt + 1'b1;
      end
      if (cmd.src_set) begin
        ran  <= 1'b1;
        pass <= NODE_W'(1);
      end else if (cmd.pass_next) begin
        pass <= pass + 1'b1;
      end
      if (cmd.pass_start) begin
        eidx    <= '0;
        changed <= 1'b0;
      end else begin
        if (cmd.edge_rd) eidx <= eidx + 1'b1;
        if (cmd.wr && imp) changed <= 1'b1;
      end
      if (cmd.res_run) begin
        cycle_found  <= changed;
        m_valid      <= 1'b1;
        out_status   <= changed ? ST_RUN_NEG : ST_RUN_OK;
        out_distance <= '0;
        out_ovf      <= ovf;
      end else if (cmd.res_query) begin
        m_valid      <= 1'b1;
        out_ovf      <= ovf;
        if (cycle_found) begin
          out_status   <= ST_INVALID;
          out_distance <= '0;
        end else if (q_hit) begin
          out_status   <= ST_VALID;
          out_distance <= rd_a[DIST_W-1:0];
        end else begin
          out_status   <= ST_UNREACH;
          out_distance <= '0;
        end
      end else if (m_ready) begin
        m_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    edge_cnt <= ECW'(MAX_EDGES)) else $error("edge count past store size");
  a_ovf_full: assert property (@(posedge clk) disable iff (rst)
    ovf |-> full) else $error("overflow flag set with room in store");
  a_dist_zero: assert property (@(posedge clk) disable iff (rst)
    (m_valid && out_status != ST_VALID) |-> (out_distance == '0))
    else $error("nonzero distance on non-distance result");
`endif

endmodule

// ===== hw/rtl/single_source_shortest_path_engine.sv =====
// usage: edges, runs and queries arrive on the s_ stream; kind rides in s_tuser.
// load edge and clear edges give no result beat.
// a run clears the node store, seeds the source, then walks the edge store
// once per pass, for up to node_count-1 passes and one more check pass; one
// result beat follows. a query gives one result beat with status in m_tuser.
// the result sits in an output register; while the receiver stalls the block
// holds it and takes no further run or query to completion.
// the user must write node_count over the apb port only while the block is
// idle; the block itself does not enforce it.
// reset (rst, synchronous) empties the edge store, clears the overflow, cycle
// and run flags so every node reads as unreached; node_count returns to 1.
// depends on sssp_pkg, sssp_ctrl and sssp_dp
`timescale 1ns / 1ps
module single_source_shortest_path_engine #(
  parameter int MAX_NODES   = sssp_pkg::MAX_NODES_DEF,
  parameter int MAX_EDGES   = sssp_pkg::MAX_EDGES_DEF,
  parameter int WEIGHT_BITS = sssp_pkg::WEIGHT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // from_node[9:0], to_node[19:10], edge_weight[35:20]
  input  logic [1:0]  s_tuser,   // kind[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // distance[31:0], edges_overflowed[32]
  output logic [2:0]  m_tuser,   // status[2:0]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import sssp_pkg::*;

  cmd_t              cmd;
  sts_t              sts;
  logic [NODE_W-1:0] node_count;
  logic [DIST_W-1:0] distance;
  logic              ovf;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_NODE_COUNT[2]) ? 32'(node_count) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= NODE_W'(1);
    end else if (psel && penable && pwrite && paddr[2] == REG_NODE_COUNT[2]) begin
      node_count <= pwdata[NODE_W-1:0];
    end
  end

  sssp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_kind  (s_tuser),
    .sts      (sts),
    .cmd      (cmd)
  );

  sssp_dp #(
    .MAX_NODES   (MAX_NODES),
    .MAX_EDGES   (MAX_EDGES),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .node_count   (node_count),
    .in_from      (s_tdata[9:0]),
    .in_to        (s_tdata[19:10]),
    .in_weight    (s_tdata[35:20]),
    .m_valid      (m_tvalid),
    .m_ready      (m_tready),
    .out_status   (m_tuser),
    .out_distance (distance),
    .out_ovf      (ovf)
  );

  assign m_tdata = {7'd0, ovf, distance};

endmodule

// ===== sim/single_source_shortest_path_engine_tb.sv =====
// self-checking bench for the shortest path engine: streams edge loads, runs
// and queries, predicts every result beat in-bench and compares field by field
// depends on sssp_pkg and single_source_shortest_path_engine
`timescale 1ns / 1ps
module single_source_shortest_path_engine_tb;
  import sssp_pkg::*;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [NODE_W-1:0] src;
    logic [NODE_W-1:0] dst;
    logic [WIN_W-1:0]  wgt;
  } cmd_beat_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [DIST_W-1:0] distance;
    logic              ovf;
  } result_t;

  localparam int EDGE_CAP = MAX_EDGES_DEF;
  localparam int NODE_CAP = MAX_NODES_DEF;
  localparam int STALL_LIMIT = 400000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic [2:0]  m_tuser;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  single_source_shortest_path_engine u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  always #10 clk = ~clk;

  // shadow of the engine state
  logic [NODE_W-1:0] sh_start [EDGE_CAP];
  logic [NODE_W-1:0] sh_end   [EDGE_CAP];
  int                sh_wgt   [EDGE_CAP];
  int                sh_loaded;
  int                sh_dist  [NODE_CAP];
  bit                sh_reach [NODE_CAP];
  bit                sh_cycle;
  bit                sh_ovf;
  int                sh_nodes;

  cmd_beat_t pending_cmds[$];
  result_t   expected_results[$];
  int        fail_cnt = 0;
  bit        quiet = 1'b0;
  int        items_made = 0;

  function automatic bit node_ok(int n);
    return n >= 1 && n <= sh_nodes && n < NODE_CAP;
  endfunction

  function automatic bit relax_all(bit apply);
    bit     changed;
    int     a, b;
    longint sum;
    changed = 1'b0;
    for (int i = 0; i < sh_loaded; i++) begin
      a = sh_start[i];
      b = sh_end[i];
      if (!node_ok(a) || !node_ok(b) || !sh_reach[a]) continue;
      sum = longint'(sh_dist[a]) + longint'(sh_wgt[i]);
      if (sum > 64'sd2147483647) sum = 64'sd2147483647;
      if (sum < -64'sd2147483648) sum = -64'sd2147483648;
      if (!sh_reach[b] || int'(sum) < sh_dist[b]) begin
        changed = 1'b1;
        if (!apply) return 1'b1;
        sh_dist[b] = int'(sum);
        sh_reach[b] = 1'b1;
      end
    end
    return changed;
  endfunction

  function automatic void predict_beat(cmd_beat_t c);
    result_t r;
    r = '0;
    case (c.kind)
      KIND_LOAD: begin
        if (sh_loaded < EDGE_CAP) begin
          sh_start[sh_loaded] = c.src;
          sh_end[sh_loaded] = c.dst;
          sh_wgt[sh_loaded] = int'($signed(c.wgt));
          sh_loaded++;
        end else begin
          sh_ovf = 1'b1;
        end
        return;
      end
      KIND_CLEAR: begin
        sh_loaded = 0;
        sh_ovf = 1'b0;
        return;
      end
      KIND_RUN: begin
        for (int n = 0; n < NODE_CAP; n++) sh_reach[n] = 1'b0;
        if (node_ok(c.src)) begin
          sh_dist[c.src] = 0;
          sh_reach[c.src] = 1'b1;
        end
        for (int p = 1; p < sh_nodes; p++)
          if (!relax_all(1'b1)) break;
        sh_cycle = relax_all(1'b0);
        r.status = sh_cycle ? ST_RUN_NEG : ST_RUN_OK;
      end
      default: begin
        if (sh_cycle) r.status = ST_INVALID;
        else if (node_ok(c.src) && sh_reach[c.src]) begin
          r.status = ST_VALID;
          r.distance = sh_dist[c.src];
        end else r.status = ST_UNREACH;
      end
    endcase
    r.ovf = sh_ovf;
    expected_results.insert(expected_results.size(), r);
  endfunction

  // command driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready)
        predict_beat({s_tuser, s_tdata[9:0], s_tdata[19:10], s_tdata[35:20]});
      if (!s_tvalid || s_tready) begin
        if (pending_cmds.size() > 0 && (quiet || $urandom_range(99) >= 21)) begin
          cmd_beat_t c;
          c = pending_cmds.pop_front();
          s_tuser <= c.kind;
          s_tdata <= {4'b0, c.wgt, c.dst, c.src};
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor, with one long hold-off early in the run
  int result_beats = 0;
  int hold_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        result_t e;
        result_beats++;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result beat status=%0d dist=%0d", $time,
                   m_tuser, $signed(m_tdata[31:0]));
          fail_cnt++;
        end else begin
          e = expected_results.pop_front();
          if (m_tuser !== e.status) begin
            $display("%0t: status expected %0d actual %0d", $time, e.status, m_tuser);
            fail_cnt++;
          end
          if (m_tdata[31:0] !== e.distance) begin
            $display("%0t: distance expected %0d actual %0d", $time,
                     $signed(e.distance), $signed(m_tdata[31:0]));
            fail_cnt++;
          end
          if (m_tdata[32] !== e.ovf) begin
            $display("%0t: overflow flag expected %0d actual %0d", $time, e.ovf, m_tdata[32]);
            fail_cnt++;
          end
        end
        if (result_beats == 12) hold_left = 2500;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= quiet || $urandom_range(99) >= 21;
      end
    end
  end

  // watchdog on cycles with no beat on either stream
  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || rst) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles == STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic push_cmd(logic [KIND_W-1:0] k, int a, int b, int w);
    cmd_beat_t c;
    c.kind = k;
    c.src = a[NODE_W-1:0];
    c.dst = b[NODE_W-1:0];
    c.wgt = w[WIN_W-1:0];
    pending_cmds.insert(pending_cmds.size(), c);
    items_made++;
  endtask

  task automatic wait_drained();
    while (pending_cmds.size() != 0 || s_tvalid || expected_results.size() != 0)
      @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic set_node_count(int n);
    wait_drained();
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= REG_NODE_COUNT;
    pwdata <= n;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sh_nodes = n & 10'h3FF;
  endtask

  function automatic int pick_node(int nc);
    int r;
    r = $urandom_range(99);
    if (r < 6) return 0;
    if (r < 10) return $urandom_range(1023);
    return (nc < 1) ? 1 : $urandom_range(nc, 1);
  endfunction

  // one graph: clear, load, run, queries; some noise mixed in
  task automatic graph_round(int nc, bit allow_neg);
    int ne, w, span;
    span = (nc > 12) ? 12 : nc;
    push_cmd(KIND_CLEAR, $urandom, $urandom, $urandom);
    ne = $urandom_range(14, 1);
    for (int i = 0; i < ne; i++) begin
      if (allow_neg && $urandom_range(3) == 0) w = -int'($urandom_range(40));
      else if ($urandom_range(15) == 0) w = $urandom;
      else w = $urandom_range(100);
      if (!allow_neg && w < 0) w = -w;
      if ($urandom_range(9) == 0 && allow_neg) w = 32'($urandom);
      push_cmd(KIND_LOAD, pick_node(span), pick_node(span), allow_neg ? w : w & 16'h7FFF);
    end
    if ($urandom_range(9) == 0)
      push_cmd(KIND_W'($urandom_range(3)), $urandom, $urandom, $urandom);
    push_cmd(KIND_RUN, pick_node(span), $urandom, $urandom);
    for (int q = $urandom_range(8, 2); q > 0; q--)
      push_cmd(KIND_QUERY, pick_node(span), $urandom, $urandom);
  endtask

  initial begin
    sh_loaded = 0;
    sh_cycle = 1'b0;
    sh_ovf = 1'b0;
    sh_nodes = 1;
    for (int n = 0; n < NODE_CAP; n++) sh_reach[n] = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed: query before run, chain with extreme weights, out-of-range nodes
    push_cmd(KIND_QUERY, 1, 0, 0);
    set_node_count(4);
    push_cmd(KIND_LOAD, 1, 2, 5);
    push_cmd(KIND_LOAD, 2, 3, -32768);
    push_cmd(KIND_LOAD, 3, 4, 32767);
    push_cmd(KIND_LOAD, 0, 2, 1);
    push_cmd(KIND_LOAD, 1, 1023, 1);
    push_cmd(KIND_RUN, 1, 1023, 0);
    for (int n = 0; n <= 4; n++) push_cmd(KIND_QUERY, n, 0, 0);
    push_cmd(KIND_QUERY, 1023, 1023, 65535);
    // negative cycle, then clear keeps the cycle verdict until the next run
    push_cmd(KIND_LOAD, 3, 2, -1);
    push_cmd(KIND_RUN, 1, 0, 0);
    push_cmd(KIND_QUERY, 2, 0, 0);
    push_cmd(KIND_CLEAR, 0, 0, 0);
    push_cmd(KIND_QUERY, 3, 0, 0);
    push_cmd(KIND_RUN, 1023, 0, 0);
    push_cmd(KIND_QUERY, 1, 0, 0);

    // unbroken stretch with no idling on either side
    set_node_count(3);
    quiet = 1'b1;
    for (int g = 0; g < 5; g++) graph_round(3, 1'b1);
    wait_drained();
    quiet = 1'b0;

    // node_count zero and one
    set_node_count(0);
    push_cmd(KIND_LOAD, 1, 1, -5);
    push_cmd(KIND_RUN, 1, 0, 0);
    push_cmd(KIND_QUERY, 1, 0, 0);
    set_node_count(1);
    graph_round(1, 1'b1);

    while (items_made < 750) begin
      int nc;
      case ($urandom_range(6))
        0: nc = 2;
        1: nc = 3;
        2: nc = 5;
        3: nc = 8;
        4: nc = 1023;
        5: nc = $urandom_range(16, 1);
        default: nc = 12;
      endcase
      set_node_count(nc);
      for (int g = $urandom_range(4, 1); g > 0; g--) graph_round(nc, nc < 100);
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/sssp_pkg.sv
hw/rtl/sssp_ctrl.sv
hw/rtl/sssp_dp.sv
hw/rtl/single_source_shortest_path_engine.sv
sim/single_source_shortest_path_engine_tb.sv
